@@ hw/rtl/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants and types for the modular exponentiation unit.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned OperandWidth = 31;
  localparam int unsigned CountWidth   = $clog2(OperandWidth);

  typedef logic [OperandWidth-1:0] operand_t;
  typedef logic [CountWidth-1:0]   count_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_MUL,
    ST_FINISH
  } state_e;

endpackage

@@ hw/rtl/modular_exponentiation_unit.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Right-to-left square-and-multiply modular exponentiation built around one
// shared double-and-add modular multiplier.
// ----------------------------------------------------------------------------
//
//  Channel | Valid        | Stall        | Payload
//  --------+--------------+--------------+-------------------------------------
//  input   | in_valid_i   | in_stall_o   | base_value_i, exponent_i, modulus_i
//  output  | out_valid_o  | out_stall_i  | power_result_o, zero_modulus_error_o
//
//  One item first reduces the base by the modulus, then, for every exponent
//  bit up to the highest set one, runs one modular multiplication per square
//  or accumulate. Each multiplication is a scan step, an add-and-double step
//  per significant multiplier bit and a step that stores the product. An
//  exponent of zero or a zero modulus goes straight to the result.
//  The input stalls from acceptance until the result sits in the output
//  register. Reset clears the state and the output valid at once; there is
//  no clearing pass.
//
module modular_exponentiation_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  modexp_pkg::operand_t     base_value_i,
  input  modexp_pkg::operand_t     exponent_i,
  input  modexp_pkg::operand_t     modulus_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output modexp_pkg::operand_t     power_result_o,
  output logic                     zero_modulus_error_o
);

  localparam int unsigned W = modexp_pkg::OperandWidth;

  modexp_pkg::state_e   state_q, state_d;
  modexp_pkg::operand_t base_q, base_d;      // base, shifted out during reduction
  modexp_pkg::operand_t exp_q, exp_d;
  modexp_pkg::operand_t mod_q, mod_d;
  modexp_pkg::operand_t acc_q, acc_d;        // running result
  modexp_pkg::operand_t pow_q, pow_d;        // current base power
  modexp_pkg::operand_t mul_acc_q, mul_acc_d;
  modexp_pkg::operand_t mul_add_q, mul_add_d;
  modexp_pkg::operand_t mul_bits_q, mul_bits_d;
  logic                 mul_sq_q, mul_sq_d;  // multiplication target is the power
  modexp_pkg::count_t   cnt_q, cnt_d;
  logic                 err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  modexp_pkg::operand_t out_res_q, out_res_d;
  logic                 out_err_q, out_err_d;

  logic                 in_xfer;
  logic                 out_free;
  logic                 mul_done;
  logic                 scan_done;
  logic [W:0]           mod_ext;
  logic [W:0]           sum;
  logic [W:0]           dbl;
  logic [W:0]           shl;
  modexp_pkg::operand_t sum_red;
  modexp_pkg::operand_t dbl_red;
  modexp_pkg::operand_t shl_red;

  assign in_stall_o = (state_q != modexp_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mul_done   = (mul_bits_q == '0);
  assign scan_done  = (exp_q == '0);

  // Shared add and compare-subtract paths. All operands stay below the modulus.
  assign mod_ext = {1'b0, mod_q};
  assign sum     = {1'b0, mul_acc_q} + {1'b0, mul_add_q};
  assign dbl     = {mul_add_q, 1'b0};
  assign shl     = {mul_acc_q, base_q[W-1]};
  assign sum_red = (sum >= mod_ext) ? W'(sum - mod_ext) : sum[W-1:0];
  assign dbl_red = (dbl >= mod_ext) ? W'(dbl - mod_ext) : dbl[W-1:0];
  assign shl_red = (shl >= mod_ext) ? W'(shl - mod_ext) : shl[W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      modexp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (exponent_i == '0 || modulus_i == '0) begin
            state_d = modexp_pkg::ST_FINISH;
          end else begin
            state_d = modexp_pkg::ST_REDUCE;
          end
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (cnt_q == '0) begin
          state_d = modexp_pkg::ST_SCAN;
        end
      end
      modexp_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = modexp_pkg::ST_FINISH;
        end else begin
          state_d = modexp_pkg::ST_MUL;
        end
      end
      modexp_pkg::ST_MUL: begin
        if (mul_done) begin
          state_d = modexp_pkg::ST_SCAN;
        end
      end
      modexp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = modexp_pkg::ST_IDLE;
        end
      end
      default: state_d = modexp_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    base_d      = base_q;
    exp_d       = exp_q;
    mod_d       = mod_q;
    acc_d       = acc_q;
    pow_d       = pow_q;
    mul_acc_d   = mul_acc_q;
    mul_add_d   = mul_add_q;
    mul_bits_d  = mul_bits_q;
    mul_sq_d    = mul_sq_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    out_err_d   = out_err_q;
    case (state_q)
      modexp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          base_d    = base_value_i;
          exp_d     = exponent_i;
          mod_d     = modulus_i;
          mul_acc_d = '0;
          cnt_d     = modexp_pkg::count_t'(W - 1);
          err_d     = 1'b0;
          // One reduced by the modulus; a modulus of one makes it zero.
          acc_d     = (modulus_i == modexp_pkg::operand_t'(1)) ? '0
                                                               : modexp_pkg::operand_t'(1);
          if (exponent_i == '0) begin
            acc_d = modexp_pkg::operand_t'(1);
          end else if (modulus_i == '0) begin
            acc_d = '0;
            err_d = 1'b1;
          end
        end
      end
      modexp_pkg::ST_REDUCE: begin
        // Restoring reduction of the base, one bit per cycle from the top.
        mul_acc_d = shl_red;
        base_d    = {base_q[W-2:0], 1'b0};
        cnt_d     = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          pow_d = shl_red;
        end
      end
      modexp_pkg::ST_SCAN: begin
        if (!scan_done) begin
          mul_acc_d = '0;
          mul_add_d = pow_q;
          if (exp_q[0]) begin
            // Accumulate step; the bit is cleared so the square follows next.
            mul_bits_d = acc_q;
            mul_sq_d   = 1'b0;
            exp_d      = {exp_q[W-1:1], 1'b0};
          end else begin
            mul_bits_d = pow_q;
            mul_sq_d   = 1'b1;
            exp_d      = {1'b0, exp_q[W-1:1]};
          end
        end
      end
      modexp_pkg::ST_MUL: begin
        if (mul_done) begin
          if (mul_sq_q) begin
            pow_d = mul_acc_q;
          end else begin
            acc_d = mul_acc_q;
          end
        end else begin
          if (mul_bits_q[0]) begin
            mul_acc_d = sum_red;
          end
          mul_add_d  = dbl_red;
          mul_bits_d = {1'b0, mul_bits_q[W-1:1]};
        end
      end
      modexp_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = acc_q;
          out_err_d   = err_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= modexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    exp_q      <= exp_d;
    mod_q      <= mod_d;
    acc_q      <= acc_d;
    pow_q      <= pow_d;
    mul_acc_q  <= mul_acc_d;
    mul_add_q  <= mul_add_d;
    mul_bits_q <= mul_bits_d;
    mul_sq_q   <= mul_sq_d;
    cnt_q      <= cnt_d;
    err_q      <= err_d;
    out_res_q  <= out_res_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o          = out_valid_q;
  assign power_result_o       = out_res_q;
  assign zero_modulus_error_o = out_err_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != modexp_pkg::ST_IDLE))
    else $error("accepted item did not start work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == modexp_pkg::ST_MUL) |-> (mul_acc_q < mod_q) && (mul_add_q < mod_q))
    else $error("multiplier operand not reduced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_modulus_error_o) |-> (power_result_o == '0))
    else $error("error result carries nonzero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && (state_q == modexp_pkg::ST_FINISH))
      |=> (state_q == modexp_pkg::ST_FINISH))
    else $error("finished result dropped while output stalled");
`endif

endmodule
